[design/url_stream_parser_top_macros.svh]
// Assertion macros shared by the checker of the URL stream parser.
// Each macro samples on clk and is disabled while rst is high.
`ifndef URL_STREAM_PARSER_TOP_MACROS_SVH
`define URL_STREAM_PARSER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define USP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("url stream parser: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define USP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("url stream parser: next-cycle check failed");

`endif

[design/usp_pkg.sv]
`default_nettype none

package usp_pkg;

  // Parse phases
  typedef enum logic [3:0] {
    PH_SCHEME     = 4'd0,
    PH_COLON      = 4'd1,
    PH_SLASH1     = 4'd2,
    PH_SLASH2     = 4'd3,
    PH_HOST_FIRST = 4'd4,
    PH_HOST       = 4'd5,
    PH_PORT_FIRST = 4'd6,
    PH_PORT       = 4'd7,
    PH_DOC        = 4'd8,
    PH_FAIL       = 4'd9
  } phase_t;

  // Field tags
  localparam logic [2:0] TAG_SCHEME = 3'd0;
  localparam logic [2:0] TAG_DELIM  = 3'd1;
  localparam logic [2:0] TAG_HOST   = 3'd2;
  localparam logic [2:0] TAG_PORT   = 3'd3;
  localparam logic [2:0] TAG_DOC    = 3'd4;
  localparam logic [2:0] TAG_BAD    = 3'd5;

  // Failure reasons
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_SCHEME = 3'd1;
  localparam logic [2:0] ERR_HOST   = 3'd2;
  localparam logic [2:0] ERR_PORT   = 3'd3;
  localparam logic [2:0] ERR_RANGE  = 3'd4;

  // Protocol codes
  localparam logic [1:0] PROTO_HTTP  = 2'd0;
  localparam logic [1:0] PROTO_HTTPS = 2'd1;
  localparam logic [1:0] PROTO_FTP   = 2'd2;

  // Scheme progress: none, h, ht, htt, http, https, f, ft
  localparam logic [2:0] SCH_NONE  = 3'd0;
  localparam logic [2:0] SCH_H     = 3'd1;
  localparam logic [2:0] SCH_HT    = 3'd2;
  localparam logic [2:0] SCH_HTT   = 3'd3;
  localparam logic [2:0] SCH_HTTP  = 3'd4;
  localparam logic [2:0] SCH_HTTPS = 3'd5;
  localparam logic [2:0] SCH_F     = 3'd6;
  localparam logic [2:0] SCH_FT    = 3'd7;

  // Configuration register indexes
  localparam logic [2:0] REG_DEFAULT_HTTP  = 3'd0;
  localparam logic [2:0] REG_DEFAULT_HTTPS = 3'd1;
  localparam logic [2:0] REG_DEFAULT_FTP   = 3'd2;
  localparam logic [2:0] REG_MIN_PORT      = 3'd3;
  localparam logic [2:0] REG_MAX_PORT      = 3'd4;

  // Port value saturates one above the largest port
  localparam logic [16:0] PORT_SAT = 17'h10000;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  scheme_so_far;
    logic [16:0] port_value;
    logic        port_overflow;
    logic        port_given;
    logic [2:0]  error_code;
    logic [1:0]  protocol;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    phase:         PH_SCHEME,
    scheme_so_far: SCH_NONE,
    port_value:    17'd0,
    port_overflow: 1'b0,
    port_given:    1'b0,
    error_code:    ERR_NONE,
    protocol:      PROTO_HTTP
  };

  typedef struct packed {
    logic [15:0] http_def_port;
    logic [15:0] https_def_port;
    logic [15:0] ftp_def_port;
    logic [15:0] min_port;
    logic [15:0] max_port;
  } cfg_t;

  typedef struct packed {
    logic        url_valid;
    logic [1:0]  protocol_code;
    logic [15:0] port_number;
    logic [2:0]  fail_reason;
  } verdict_t;

endpackage

`default_nettype wire

[design/usp_cfg_regs.sv]
`default_nettype none

module usp_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data,
  output usp_pkg::cfg_t     cfg
);
  import usp_pkg::*;

  // Write one register per beat; drop indexes past the list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.http_def_port  <= 16'd80;
      cfg.https_def_port <= 16'd443;
      cfg.ftp_def_port   <= 16'd21;
      cfg.min_port       <= 16'd1;
      cfg.max_port       <= 16'hFFFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEFAULT_HTTP:  cfg.http_def_port  <= cfg_data;
        REG_DEFAULT_HTTPS: cfg.https_def_port <= cfg_data;
        REG_DEFAULT_FTP:   cfg.ftp_def_port   <= cfg_data;
        REG_MIN_PORT:      cfg.min_port       <= cfg_data;
        REG_MAX_PORT:      cfg.max_port       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/usp_step.sv]
`default_nettype none

module usp_step (
  input  wire logic [7:0]          byte_in,
  input  wire usp_pkg::parse_state_t st,
  output usp_pkg::parse_state_t    st_next,
  output logic [2:0]               tag
);
  import usp_pkg::*;

  logic [7:0]  lc;
  logic        is_digit;
  logic        is_host;
  logic        is_space;
  logic [19:0] pv_wide;
  logic [19:0] pv_acc;
  logic        fail_en;
  logic [2:0]  fail_code;

  // Classify the byte
  always_comb begin
    lc       = byte_in | 8'h20;
    is_digit = (byte_in >= 8'h30) && (byte_in <= 8'h39);
    is_host  = is_digit || ((lc >= 8'h61) && (lc <= 8'h7A)) ||
               (byte_in == 8'h2E) || (byte_in == 8'h2D);
    is_space = (byte_in == 8'h20) || ((byte_in >= 8'h09) && (byte_in <= 8'h0D));
    pv_wide  = {3'b000, st.port_value};
    pv_acc   = (pv_wide << 3) + (pv_wide << 1) + {16'd0, byte_in[3:0]};
  end

  // Advance the pattern by one byte
  always_comb begin
    st_next   = st;
    tag       = TAG_BAD;
    fail_en   = 1'b0;
    fail_code = ERR_NONE;
    unique case (st.phase)
      PH_SCHEME: begin
        fail_en   = 1'b1;
        fail_code = ERR_SCHEME;
        unique case (st.scheme_so_far)
          SCH_NONE: begin
            if (lc == 8'h68) begin
              st_next.scheme_so_far = SCH_H;
              fail_en = 1'b0;
            end else if (lc == 8'h66) begin
              st_next.scheme_so_far = SCH_F;
              fail_en = 1'b0;
            end
          end
          SCH_H, SCH_HT: begin
            if (lc == 8'h74) begin
              st_next.scheme_so_far = st.scheme_so_far + 3'd1;
              fail_en = 1'b0;
            end
          end
          SCH_HTT: begin
            if (lc == 8'h70) begin
              st_next.scheme_so_far = SCH_HTTP;
              fail_en = 1'b0;
            end
          end
          SCH_HTTP: begin
            if (lc == 8'h73) begin
              st_next.scheme_so_far = SCH_HTTPS;
              st_next.protocol      = PROTO_HTTPS;
              st_next.phase         = PH_COLON;
              fail_en = 1'b0;
            end else if (byte_in == 8'h3A) begin
              st_next.protocol = PROTO_HTTP;
              st_next.phase    = PH_SLASH1;
              fail_en = 1'b0;
            end
          end
          SCH_F: begin
            if (lc == 8'h74) begin
              st_next.scheme_so_far = SCH_FT;
              fail_en = 1'b0;
            end
          end
          SCH_FT: begin
            if (lc == 8'h70) begin
              st_next.protocol = PROTO_FTP;
              st_next.phase    = PH_COLON;
              fail_en = 1'b0;
            end
          end
          default: ;
        endcase
        // Colon right after "http" is a delimiter, not a scheme letter
        if (!fail_en) begin
          tag = (st.scheme_so_far == SCH_HTTP && byte_in == 8'h3A) ? TAG_DELIM : TAG_SCHEME;
        end
      end
      PH_COLON: begin
        if (byte_in == 8'h3A) begin
          st_next.phase = PH_SLASH1;
          tag = TAG_DELIM;
        end else begin
          fail_en   = 1'b1;
          fail_code = ERR_SCHEME;
        end
      end
      PH_SLASH1, PH_SLASH2: begin
        if (byte_in == 8'h2F) begin
          st_next.phase = (st.phase == PH_SLASH1) ? PH_SLASH2 : PH_HOST_FIRST;
          tag = TAG_DELIM;
        end else begin
          fail_en   = 1'b1;
          fail_code = ERR_HOST;
        end
      end
      PH_HOST_FIRST: begin
        if (is_host) begin
          st_next.phase = PH_HOST;
          tag = TAG_HOST;
        end else begin
          fail_en   = 1'b1;
          fail_code = ERR_HOST;
        end
      end
      PH_HOST: begin
        if (is_host) begin
          tag = TAG_HOST;
        end else if (byte_in == 8'h3A) begin
          st_next.phase      = PH_PORT_FIRST;
          st_next.port_given = 1'b1;
          tag = TAG_DELIM;
        end else if (byte_in == 8'h2F) begin
          st_next.phase = PH_DOC;
          tag = TAG_DELIM;
        end else begin
          fail_en   = 1'b1;
          fail_code = ERR_HOST;
        end
      end
      PH_PORT_FIRST, PH_PORT: begin
        if (is_digit) begin
          // Saturate one above the largest port and mark overflow
          if (pv_acc > 20'hFFFF) begin
            st_next.port_overflow = 1'b1;
            st_next.port_value    = PORT_SAT;
          end else begin
            st_next.port_value = pv_acc[16:0];
          end
          st_next.phase = PH_PORT;
          tag = TAG_PORT;
        end else if (st.phase == PH_PORT && byte_in == 8'h2F) begin
          st_next.phase = PH_DOC;
          tag = TAG_DELIM;
        end else begin
          fail_en   = 1'b1;
          fail_code = ERR_PORT;
        end
      end
      PH_DOC: begin
        if (!is_space) begin
          tag = TAG_DOC;
        end else begin
          fail_en   = 1'b1;
          fail_code = ERR_HOST;
        end
      end
      default: ;
    endcase

    // Keep the first error; all later bytes stay invalid
    if (fail_en) begin
      st_next.phase = PH_FAIL;
      tag = TAG_BAD;
      if (st.error_code == ERR_NONE) begin
        st_next.error_code = fail_code;
      end
    end
  end

endmodule

`default_nettype wire

[design/usp_verdict.sv]
`default_nettype none

module usp_verdict (
  input  wire usp_pkg::parse_state_t st,
  input  wire usp_pkg::cfg_t         cfg,
  output usp_pkg::verdict_t          verdict
);
  import usp_pkg::*;

  logic [2:0]  err;
  logic [15:0] port;

  always_comb begin
    err  = st.error_code;
    port = 16'd0;

    // Blame the part that is still incomplete
    if (err == ERR_NONE) begin
      unique case (st.phase)
        PH_SCHEME, PH_COLON:                 err = ERR_SCHEME;
        PH_PORT_FIRST:                       err = ERR_PORT;
        PH_SLASH1, PH_SLASH2, PH_HOST_FIRST: err = ERR_HOST;
        default: ;
      endcase
    end

    // Pick the explicit or default port and range check it
    if (err == ERR_NONE) begin
      if (st.port_given) begin
        port = st.port_value[16] ? 16'hFFFF : st.port_value[15:0];
      end else if (st.protocol == PROTO_HTTPS) begin
        port = cfg.https_def_port;
      end else if (st.protocol == PROTO_FTP) begin
        port = cfg.ftp_def_port;
      end else begin
        port = cfg.http_def_port;
      end
      if (st.port_overflow || (port < cfg.min_port) || (port > cfg.max_port)) begin
        err = ERR_RANGE;
      end
    end

    verdict.url_valid     = (err == ERR_NONE);
    verdict.protocol_code = st.protocol;
    verdict.port_number   = port;
    verdict.fail_reason   = err;
  end

endmodule

`default_nettype wire

[design/url_stream_parser_top.sv]
// URL stream parser.
// Input channel: one URL byte per beat on byte_in, with last_byte high on the
// final byte. Handshake: in_valid from the sender, in_stall from this block.
// Output channel: one result per input byte (byte_out, field_tag, url_end and,
// on the url_end beat, url_valid, protocol_code, port_number, fail_reason),
// handshake out_valid from this block, out_stall from the receiver.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data write the
// default ports and the port range; cfg_ready is always high. Write only while
// no byte is in flight.
// A result appears in the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the receiver does not stall, set by the single output register.
// The parse state register steps once per accepted byte and returns to the
// start of the pattern after a last_byte beat.
// When the receiver stalls with a result held, in_stall rises and the held
// result stays unchanged until taken.
// Reset clears the parse state, empties the output register and loads the
// register reset values.
`default_nettype none

module url_stream_parser_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  byte_in,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       byte_out,
  output logic [2:0]       field_tag,
  output logic             url_end,
  output logic             url_valid,
  output logic [1:0]       protocol_code,
  output logic [15:0]      port_number,
  output logic [2:0]       fail_reason,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import usp_pkg::*;

  cfg_t         cfg;
  parse_state_t st;
  parse_state_t st_next;
  verdict_t     verdict;
  logic [2:0]   tag;
  logic         in_fire;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign in_fire   = in_valid && !in_stall;

  usp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  usp_step u_step (
    .byte_in (byte_in),
    .st      (st),
    .st_next (st_next),
    .tag     (tag)
  );

  usp_verdict u_verdict (
    .st      (st_next),
    .cfg     (cfg),
    .verdict (verdict)
  );

  // Advance the parse state; restart after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= PARSE_RESET;
    end else if (in_fire) begin
      st <= last_byte ? PARSE_RESET : st_next;
    end
  end

  // Track output occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_out  <= byte_in;
      field_tag <= tag;
      url_end   <= last_byte;
      if (last_byte) begin
        url_valid     <= verdict.url_valid;
        protocol_code <= verdict.protocol_code;
        port_number   <= verdict.port_number;
        fail_reason   <= verdict.fail_reason;
      end else begin
        url_valid     <= 1'b0;
        protocol_code <= PROTO_HTTP;
        port_number   <= 16'd0;
        fail_reason   <= ERR_NONE;
      end
    end
  end

endmodule

`default_nettype wire

[design/usp_checker.sv]
`default_nettype none
`include "url_stream_parser_top_macros.svh"

module usp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  byte_in,
  input wire logic        last_byte,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  byte_out,
  input wire logic [2:0]  field_tag,
  input wire logic        url_end,
  input wire logic        url_valid,
  input wire logic [1:0]  protocol_code,
  input wire logic [15:0] port_number,
  input wire logic [2:0]  fail_reason
);
  import usp_pkg::*;

  logic [33:0] out_beat;
  logic [8:0]  in_beat;
  logic [8:0]  echo_beat;
  logic        verdict_clear;

  // Group the port bundles the checks look at
  assign out_beat      = {byte_out, field_tag, url_end, url_valid, protocol_code,
                          port_number, fail_reason};
  assign in_beat       = {byte_in, last_byte};
  assign echo_beat     = {byte_out, url_end};
  assign verdict_clear = !url_valid && (protocol_code == PROTO_HTTP) &&
                         (port_number == 16'd0) && (fail_reason == ERR_NONE);

  // A stalled result beat holds
  `USP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_beat))

  // An accepted byte is echoed in the next beat
  `USP_ASSERT_NEXT(a_echo, in_valid && !in_stall, out_valid && echo_beat == $past(in_beat))

  // Verdict fields are zero away from the end of a URL
  `USP_ASSERT_SAME(a_mid_zero, out_valid && !url_end, verdict_clear)

  // Valid verdict exactly when no failure reason
  `USP_ASSERT_SAME(a_verdict, out_valid && url_end, url_valid == (fail_reason == ERR_NONE))

endmodule

bind url_stream_parser_top usp_checker u_usp_checker (.*);

`default_nettype wire
